/* rtl/u16550_pkg.sv */
// ----------------------------------------------------------------------------
// u16550_pkg: shared definitions for the 16550-style UART register block
// Operation codes, register offsets, register bit constants, the FIFO
// control word and the receive trigger level table.
// ----------------------------------------------------------------------------
package u16550_pkg;

  // Default FIFO depth in bytes.
  localparam int FIFO_DEPTH_DEF = 16;

  // Kinds of input word.
  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_LINE_RX = 2'd2,
    OP_TX_TICK = 2'd3
  } op_e;

  // Register offsets from the port base.
  localparam logic [2:0] REG_RBR_THR = 3'd0;
  localparam logic [2:0] REG_IER     = 3'd1;
  localparam logic [2:0] REG_IIR     = 3'd2;
  localparam logic [2:0] REG_LCR     = 3'd3;
  localparam logic [2:0] REG_MCR     = 3'd4;
  localparam logic [2:0] REG_LSR     = 3'd5;
  localparam logic [2:0] REG_MSR     = 3'd6;
  localparam logic [2:0] REG_SCR     = 3'd7;

  // Interrupt identification values.
  localparam logic [7:0] IIR_NO_IRQ   = 8'h01;
  localparam logic [7:0] IIR_FIFO_ON  = 8'hC0;

  // Control word from the register logic to one FIFO.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctrl_t;

  // Receive trigger level for a selector, limited to the FIFO depth.
  function automatic int trig_level(logic [1:0] sel, int depth);
    int lvl;
    case (sel)
      2'd0:    lvl = 1;
      2'd1:    lvl = 4;
      2'd2:    lvl = 8;
      default: lvl = 14;
    endcase
    if (lvl > depth) begin
      lvl = depth;
    end
    return lvl;
  endfunction

endpackage

/* rtl/u16550_in_if.sv */
// ----------------------------------------------------------------------------
// u16550_in_if: input channel of the UART register block
// Carries one bus access or line event per word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface u16550_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [2:0] reg_offset;
  logic [7:0] write_data;
  logic [7:0] line_byte;

  modport source (output valid, output operation, output reg_offset,
                  output write_data, output line_byte, input ready);
  modport sink (input valid, input operation, input reg_offset,
                input write_data, input line_byte, output ready);
endinterface

/* rtl/u16550_out_if.sv */
// ----------------------------------------------------------------------------
// u16550_out_if: result channel of the UART register block
// Carries one result word per accepted input word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface u16550_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       rx_trigger_reached;

  modport source (output valid, output read_data, output tx_valid,
                  output tx_byte, output rx_trigger_reached, input ready);
  modport sink (input valid, input read_data, input tx_valid,
                input tx_byte, input rx_trigger_reached, output ready);
endinterface

/* rtl/u16550_fifo_cell.sv */
// ----------------------------------------------------------------------------
// u16550_fifo_cell: one byte cell of a shifting FIFO
// Loads a pushed byte, or takes its neighbor's byte when the FIFO pops.
// ----------------------------------------------------------------------------
module u16550_fifo_cell (
  input  logic       clk_i,
  input  logic       load_i,
  input  logic       shift_i,
  input  logic [7:0] load_data_i,
  input  logic [7:0] next_data_i,
  output logic [7:0] data_o
);

  logic [7:0] data_q;
  logic [7:0] data_d;

  // A push lands in the first free cell; a pop moves every byte one cell
  // toward the head.
  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = load_data_i;
    end else if (shift_i) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* rtl/u16550_fifo.sv */
// ----------------------------------------------------------------------------
// u16550_fifo: byte FIFO built as a chain of shifting cells
// The oldest byte always sits in cell zero; a fill counter marks the tail.
// ----------------------------------------------------------------------------
module u16550_fifo #(
  parameter int FIFO_DEPTH = u16550_pkg::FIFO_DEPTH_DEF,
  parameter int FILL_W     = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  u16550_pkg::fifo_ctrl_t ctrl_i,
  input  logic [7:0]             push_data_i,
  output logic [7:0]             head_data_o,
  output logic [FILL_W-1:0]      fill_o
);

  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] fill_d;
  logic [7:0]        cell_data [FIFO_DEPTH];

  // Row of cells; each one hands its byte to the cell ahead on a pop.
  for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
    logic [7:0] next_data;
    if (i == FIFO_DEPTH - 1) begin : g_last
      assign next_data = cell_data[i];
    end else begin : g_mid
      assign next_data = cell_data[i + 1];
    end
    u16550_fifo_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (ctrl_i.push && (fill_q == FILL_W'(i))),
      .shift_i     (ctrl_i.pop),
      .load_data_i (push_data_i),
      .next_data_i (next_data),
      .data_o      (cell_data[i])
    );
  end

  // Fill counter; a clear only drops the count, the cells keep stale bytes.
  always_comb begin
    fill_d = fill_q;
    if (ctrl_i.clear) begin
      fill_d = '0;
    end else if (ctrl_i.push) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (ctrl_i.pop) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign head_data_o = cell_data[0];
  assign fill_o      = fill_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(FIFO_DEPTH))
    else $error("FIFO fill count exceeds its depth");
  a_push_pop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.push && ctrl_i.pop))
    else $error("FIFO pushed and popped in one cycle");
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> (fill_q == '0))
    else $error("FIFO not empty after clear");
`endif

endmodule

/* rtl/uart_16550_register_block_top.sv */
// ----------------------------------------------------------------------------
// uart_16550_register_block_top: 16550-style UART register block
// Register map, divisor latch, line/modem control and two byte FIFOs.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one word per access: a register read or write, a byte
//   received from the line, or a transmit tick that sends one queued byte.
//   out_o returns exactly one result word for every accepted input word:
//   the read value, the byte sent on the line and the receive trigger flag.
//   The result sits in the output register in the cycle after the input
//   word is accepted. Throughput is one word per cycle while out_o is not
//   stalled; every register and FIFO update completes in the accepting cycle.
//   The two FIFOs are rows of shifting byte cells with fill counters, so a
//   push or a pop updates the cells and the fill count together.
//   If the receiver stalls out_o, the result is held and in_i.ready stays
//   low until the output register is taken; it may be refilled in the same
//   cycle it is emptied.
//   Reset clears the register map, the FIFO fill counts and the output valid
//   flag; no clearing pass is run and the block accepts words right away.
// ----------------------------------------------------------------------------
module uart_16550_register_block_top #(
  parameter int FIFO_DEPTH = u16550_pkg::FIFO_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  u16550_in_if.sink    in_i,
  u16550_out_if.source out_o
);

  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

  // Architectural registers.
  logic [15:0] div_q, div_d;
  logic [7:0]  lcr_q, lcr_d;
  logic [3:0]  ier_q, ier_d;
  logic        fifo_en_q, fifo_en_d;
  logic [1:0]  trig_sel_q, trig_sel_d;
  logic [4:0]  mcr_q, mcr_d;
  logic [7:0]  scr_q, scr_d;
  logic        overrun_q, overrun_d;

  // Output register.
  logic        out_valid_q;
  logic [7:0]  rd_q, rd_d;
  logic        tv_q, tv_d;
  logic [7:0]  tb_q, tb_d;
  logic        trig_q, trig_d;

  // FIFO connections.
  u16550_pkg::fifo_ctrl_t rx_ctrl, tx_ctrl;
  logic [7:0]        rx_push_data;
  logic [7:0]        rx_head, tx_head;
  logic [FILL_W-1:0] rx_fill, tx_fill, rx_fill_nx, trig_lvl;

  logic            in_acc;
  logic            dlab, loop_mode, rx_full, tx_full, fifo_chg;
  u16550_pkg::op_e op;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign op         = u16550_pkg::op_e'(in_i.operation);
  assign dlab       = lcr_q[7];
  assign loop_mode  = mcr_q[4];
  assign rx_full    = fifo_en_q ? (rx_fill == FILL_W'(FIFO_DEPTH)) : (rx_fill != '0);
  assign tx_full    = fifo_en_q ? (tx_fill == FILL_W'(FIFO_DEPTH)) : (tx_fill != '0);
  assign fifo_chg   = in_i.write_data[0] != fifo_en_q;

  u16550_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .FILL_W     (FILL_W)
  ) u_rx_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (rx_ctrl),
    .push_data_i (rx_push_data),
    .head_data_o (rx_head),
    .fill_o      (rx_fill)
  );

  u16550_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .FILL_W     (FILL_W)
  ) u_tx_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (tx_ctrl),
    .push_data_i (in_i.write_data),
    .head_data_o (tx_head),
    .fill_o      (tx_fill)
  );

  // Decode of one input word into register updates, FIFO controls and result.
  always_comb begin
    div_d        = div_q;
    lcr_d        = lcr_q;
    ier_d        = ier_q;
    fifo_en_d    = fifo_en_q;
    trig_sel_d   = trig_sel_q;
    mcr_d        = mcr_q;
    scr_d        = scr_q;
    overrun_d    = overrun_q;
    rx_ctrl      = '0;
    tx_ctrl      = '0;
    rx_push_data = in_i.write_data;
    rd_d         = '0;
    tv_d         = 1'b0;
    tb_d         = '0;
    if (in_acc) begin
      case (op)
        u16550_pkg::OP_READ: begin
          case (in_i.reg_offset)
            u16550_pkg::REG_RBR_THR: begin
              if (dlab) begin
                rd_d = div_q[7:0];
              end else if (rx_fill != '0) begin
                rd_d        = rx_head;
                rx_ctrl.pop = 1'b1;
              end
            end
            u16550_pkg::REG_IER: begin
              rd_d = dlab ? div_q[15:8] : {4'b0, ier_q};
            end
            u16550_pkg::REG_IIR: begin
              rd_d = u16550_pkg::IIR_NO_IRQ |
                     (fifo_en_q ? u16550_pkg::IIR_FIFO_ON : 8'h00);
            end
            u16550_pkg::REG_LCR: rd_d = lcr_q;
            u16550_pkg::REG_MCR: rd_d = {3'b0, mcr_q};
            u16550_pkg::REG_LSR: begin
              rd_d = {1'b0, tx_fill == '0, tx_fill == '0, 3'b0, overrun_q,
                      rx_fill != '0};
              overrun_d = 1'b0;
            end
            u16550_pkg::REG_MSR: begin
              if (loop_mode) begin
                rd_d = {mcr_q[3], mcr_q[2], mcr_q[0], mcr_q[1], 4'b0};
              end
            end
            default: rd_d = scr_q;
          endcase
        end
        u16550_pkg::OP_WRITE: begin
          case (in_i.reg_offset)
            u16550_pkg::REG_RBR_THR: begin
              if (dlab) begin
                div_d[7:0] = in_i.write_data;
              end else if (loop_mode) begin
                if (rx_full) begin
                  overrun_d = 1'b1;
                end else begin
                  rx_ctrl.push = 1'b1;
                end
              end else if (!tx_full) begin
                tx_ctrl.push = 1'b1;
              end
            end
            u16550_pkg::REG_IER: begin
              if (dlab) begin
                div_d[15:8] = in_i.write_data;
              end else begin
                ier_d = in_i.write_data[3:0];
              end
            end
            u16550_pkg::REG_IIR: begin
              rx_ctrl.clear = fifo_chg || in_i.write_data[1];
              tx_ctrl.clear = fifo_chg || in_i.write_data[2];
              fifo_en_d     = in_i.write_data[0];
              trig_sel_d    = in_i.write_data[7:6];
            end
            u16550_pkg::REG_LCR: lcr_d = in_i.write_data;
            u16550_pkg::REG_MCR: mcr_d = in_i.write_data[4:0];
            u16550_pkg::REG_SCR: scr_d = in_i.write_data;
            default: ;
          endcase
        end
        u16550_pkg::OP_LINE_RX: begin
          // The receiver is cut off from the line in loopback.
          if (!loop_mode) begin
            rx_push_data = in_i.line_byte;
            if (rx_full) begin
              overrun_d = 1'b1;
            end else begin
              rx_ctrl.push = 1'b1;
            end
          end
        end
        default: begin
          // Transmit tick: send the oldest queued byte, or loop it back.
          if (tx_fill != '0) begin
            tx_ctrl.pop = 1'b1;
            if (loop_mode) begin
              rx_push_data = tx_head;
              if (rx_full) begin
                overrun_d = 1'b1;
              end else begin
                rx_ctrl.push = 1'b1;
              end
            end else begin
              tv_d = 1'b1;
              tb_d = tx_head;
            end
          end
        end
      endcase
    end
  end

  // Receive fill after this word, compared against the new trigger level.
  always_comb begin
    rx_fill_nx = rx_fill;
    if (rx_ctrl.clear) begin
      rx_fill_nx = '0;
    end else if (rx_ctrl.push) begin
      rx_fill_nx = rx_fill + FILL_W'(1);
    end else if (rx_ctrl.pop) begin
      rx_fill_nx = rx_fill - FILL_W'(1);
    end
    trig_lvl = fifo_en_d ? FILL_W'(u16550_pkg::trig_level(trig_sel_d, FIFO_DEPTH))
                         : FILL_W'(1);
    trig_d   = rx_fill_nx >= trig_lvl;
  end

  // Register file and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q       <= '0;
      lcr_q       <= '0;
      ier_q       <= '0;
      fifo_en_q   <= 1'b0;
      trig_sel_q  <= '0;
      mcr_q       <= '0;
      scr_q       <= '0;
      overrun_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      div_q      <= div_d;
      lcr_q      <= lcr_d;
      ier_q      <= ier_d;
      fifo_en_q  <= fifo_en_d;
      trig_sel_q <= trig_sel_d;
      mcr_q      <= mcr_d;
      scr_q      <= scr_d;
      overrun_q  <= overrun_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded when a word is accepted.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q   <= rd_d;
      tv_q   <= tv_d;
      tb_q   <= tb_d;
      trig_q <= trig_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.read_data          = rd_q;
  assign out_o.tx_valid           = tv_q;
  assign out_o.tx_byte            = tb_q;
  assign out_o.rx_trigger_reached = trig_q;

`ifndef NO_ASSERTIONS
  a_rx_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fifo_en_q |-> (rx_fill <= FILL_W'(1)))
    else $error("Receive FIFO holds more than one byte with FIFOs disabled");
  a_tx_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fifo_en_q |-> (tx_fill <= FILL_W'(1)))
    else $error("Transmit FIFO holds more than one byte with FIFOs disabled");
  a_lsr_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op == u16550_pkg::OP_READ) &&
     (in_i.reg_offset == u16550_pkg::REG_LSR)) |=> !overrun_q)
    else $error("Overrun flag not cleared by a line status read");
`endif

endmodule
